/* hw/rtl/byte_memory_cpu_core_macros.svh */
// Assertion helpers for the core RTL file
`ifndef BYTE_MEMORY_CPU_CORE_MACROS_SVH
`define BYTE_MEMORY_CPU_CORE_MACROS_SVH
// Implication checked on every edge outside reset
`define BMC_ASSERT_IMP(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) else $error(msg);
// Next-cycle implication checked outside reset
`define BMC_ASSERT_NEXT(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) else $error(msg);
`endif

/* hw/rtl/bmc_pkg.sv */
package bmc_pkg;
   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] address;
      logic [7:0]  byte_value;
      logic [3:0]  reg_index;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] pc;
      logic        equal_flag;
      logic        greater_flag;
      logic [31:0] value;
   } rsp_type;

   localparam logic [1:0] KIND_WRITE = 2'd0;
   localparam logic [1:0] KIND_SETPC = 2'd1;
   localparam logic [1:0] KIND_STEP  = 2'd2;
   localparam logic [1:0] KIND_READ  = 2'd3;

   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_HALT    = 3'd1;
   localparam logic [2:0] ST_BADOP   = 3'd2;
   localparam logic [2:0] ST_PUSHF   = 3'd3;
   localparam logic [2:0] ST_POPF    = 3'd4;
   localparam logic [2:0] ST_BADTYPE = 3'd5;

   localparam logic [7:0] OP_ADD = 8'd0,  OP_SUB = 8'd1,  OP_MUL = 8'd2,  OP_DIV = 8'd3;
   localparam logic [7:0] OP_MOV = 8'd4,  OP_LOAD = 8'd5, OP_STORE = 8'd6, OP_AND = 8'd7;
   localparam logic [7:0] OP_NOT = 8'd8,  OP_OR = 8'd9,   OP_XOR = 8'd10, OP_CMP = 8'd11;
   localparam logic [7:0] OP_JMP = 8'd12, OP_JMPE = 8'd13, OP_JMPNE = 8'd14;
   localparam logic [7:0] OP_JMPG = 8'd15, OP_JMPL = 8'd16, OP_HALT = 8'd17;
   localparam logic [7:0] OP_INT = 8'd18, OP_IRET = 8'd19, OP_LOADB = 8'd20;
   localparam logic [7:0] OP_STOREB = 8'd21, OP_CALL = 8'd22, OP_RET = 8'd23;
   localparam logic [7:0] OP_PUSH = 8'd24, OP_POP = 8'd25;

   localparam logic [31:0] SP_RESET   = 32'h000F_FFFF;
   localparam logic [31:0] POP_LIMIT  = 32'h000F_FFFC;
   localparam logic [31:0] PUSH_LIMIT = 32'h0000_0004;
   localparam logic [3:0]  SP_INDEX   = 4'd11;
   localparam logic [3:0]  NUM_REGS   = 4'd12;

   // divider handshake
   typedef struct packed {
      logic        start;
      logic [31:0] dividend;
      logic [31:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [31:0] quotient;
      logic [31:0] remainder;
   } div_rsp_type;
endpackage

/* hw/rtl/bmc_byte_ram.sv */
// Byte store: one port, registered read
module bmc_byte_ram #(
   parameter int ADDR_W = 20
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] addr,
   input  logic [7:0]        wdata,
   output logic [7:0]        rdata
);
   logic [7:0] mem [0:(1<<ADDR_W)-1];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end
endmodule

/* hw/rtl/bmc_divider.sv */
// Restoring divider, one quotient bit per cycle
module bmc_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  bmc_pkg::div_req_type div_req,
   output bmc_pkg::div_rsp_type div_rsp
);
   logic [5:0]  count_ff, count_in;
   logic        busy_ff, busy_in;
   logic [31:0] quo_ff, quo_in, rem_ff, rem_in, dsr_ff, dsr_in;
   logic        done_ff, done_in;
   logic [32:0] trial;

   always_comb begin
      count_in = count_ff;
      busy_in  = busy_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      dsr_in   = dsr_ff;
      done_in  = 1'b0;
      trial    = {rem_ff, quo_ff[31]} - {1'b0, dsr_ff};
      if (div_req.start) begin
         busy_in  = 1'b1;
         count_in = 6'd32;
         quo_in   = div_req.dividend;
         rem_in   = '0;
         dsr_in   = div_req.divisor;
      end else if (busy_ff) begin
         if (!trial[32]) begin
            rem_in = trial[31:0];
            quo_in = {quo_ff[30:0], 1'b1};
         end else begin
            rem_in = {rem_ff[30:0], quo_ff[31]};
            quo_in = {quo_ff[30:0], 1'b0};
         end
         count_in = count_ff - 6'd1;
         if (count_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = quo_ff;
   assign div_rsp.remainder = rem_ff;
endmodule

/* hw/rtl/byte_memory_cpu_core.sv */
// byte_memory_cpu_core: small 32-bit CPU stepped by the host.
// req_ channel (valid/ready) carries one transaction of kind: write memory
// byte, set PC, execute one instruction, or read a register. Every request
// gives exactly one rsp_ transaction with status, PC, flags and value.
// One request is in flight at a time; ready is high only when the sequencer
// is idle and the response register is free.
// Write byte, set PC and register read go straight to the response state.
// A step makes eight fetch reads on the single byte port, then executes;
// a word load, pop or return then reads four bytes, a word store, push or
// call writes four bytes, a byte load or store moves one byte, and a divide
// waits for the divider, which makes one quotient bit per cycle.
// The byte store is undefined until written. Reset (synchronous, active
// high) clears the registers (SP to 0xFFFFF), PC, flags, count and halt.
// A stalled response holds in the output register until rsp_ready.
`include "byte_memory_cpu_core_macros.svh"
module byte_memory_cpu_core #(
   parameter int MEM_BYTES = 1048576
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  bmc_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output bmc_pkg::rsp_type  rsp_data
);
   localparam int ADDR_W = $clog2(MEM_BYTES);

   localparam logic [3:0] S_IDLE = 4'd0, S_FETCH = 4'd1, S_EXEC = 4'd2,
                          S_RDW = 4'd3, S_WRW = 4'd4, S_DIV = 4'd5,
                          S_DONE = 4'd6, S_READB = 4'd7, S_MEMW = 4'd8;

   logic [3:0]  state_ff, state_in;
   logic [31:0] regs_ff [0:11];
   logic [31:0] pc_ff, pc_in, icount_ff, icount_in;
   logic        eq_ff, eq_in, gt_ff, gt_in, halt_ff, halt_in;
   logic [63:0] ibuf_ff, ibuf_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic [31:0] maddr_ff, maddr_in, wdat_ff, wdat_in, rword_ff, rword_in;
   logic [31:0] fpc_ff, fpc_in;
   logic        rdpend_ff, rdpend_in;
   bmc_pkg::rsp_type rsp_ff, rsp_in;
   logic        rspv_ff, rspv_in;

   // register-file writeback
   logic        rw_en;
   logic [3:0]  rw_idx;
   logic [31:0] rw_val;
   logic        rw2_en;
   logic [3:0]  rw2_idx;
   logic [31:0] rw2_val;

   logic              ram_we;
   logic [ADDR_W-1:0] ram_addr;
   logic [7:0]        ram_wdata, ram_rdata;

   bmc_pkg::div_req_type div_req;
   bmc_pkg::div_rsp_type div_rsp;

   bmc_byte_ram #(.ADDR_W(ADDR_W)) u_ram (
      .clock(clock), .we(ram_we), .addr(ram_addr),
      .wdata(ram_wdata), .rdata(ram_rdata)
   );

   bmc_divider u_div (.clock(clock), .reset(reset), .div_req(div_req), .div_rsp(div_rsp));

   // decoded instruction fields
   logic [7:0]  op, ty, r1;
   logic [31:0] a2, x, y, sp, mul_lo;
   assign op = ibuf_ff[63:56];
   assign ty = ibuf_ff[55:48];
   assign r1 = ibuf_ff[39:32];
   assign a2 = ibuf_ff[31:0];
   assign sp = regs_ff[11];

   function automatic logic [31:0] rd_reg(input logic [31:0] i, input logic [31:0] r [0:11]);
      rd_reg = (i < 32'd12) ? r[i[3:0]] : 32'd0;
   endfunction

   assign x = rd_reg({24'd0, r1}, regs_ff);
   assign y = (ty == 8'd0) ? rd_reg(a2, regs_ff) : a2;
   assign mul_lo = x * y;

   assign req_ready = (state_ff == S_IDLE) && !rspv_ff;
   assign rsp_valid = rspv_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      logic [31:0] v;
      logic        wr;
      logic [2:0]  st;
      state_in = state_ff;
      pc_in = pc_ff; icount_in = icount_ff;
      eq_in = eq_ff; gt_in = gt_ff; halt_in = halt_ff;
      ibuf_in = ibuf_ff; cnt_in = cnt_ff;
      maddr_in = maddr_ff; wdat_in = wdat_ff; rword_in = rword_ff;
      fpc_in = fpc_ff; rdpend_in = 1'b0;
      rsp_in = rsp_ff;
      rspv_in = rspv_ff && !rsp_ready;
      rw_en = 1'b0; rw_idx = '0; rw_val = '0;
      rw2_en = 1'b0; rw2_idx = '0; rw2_val = '0;
      ram_we = 1'b0; ram_addr = maddr_ff[ADDR_W-1:0]; ram_wdata = '0;
      div_req.start = 1'b0; div_req.dividend = x; div_req.divisor = y;
      v = '0; wr = 1'b0; st = bmc_pkg::ST_OK;

      case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               rsp_in.status = bmc_pkg::ST_OK;
               rsp_in.value  = '0;
               case (req_data.kind)
                  bmc_pkg::KIND_WRITE: begin
                     ram_we = 1'b1;
                     ram_addr = req_data.address[ADDR_W-1:0];
                     ram_wdata = req_data.byte_value;
                     state_in = S_DONE;
                  end
                  bmc_pkg::KIND_SETPC: begin
                     pc_in = req_data.address;
                     state_in = S_DONE;
                  end
                  bmc_pkg::KIND_STEP: begin
                     if (halt_ff) begin
                        rsp_in.status = bmc_pkg::ST_HALT;
                        state_in = S_DONE;
                     end else begin
                        fpc_in = pc_ff;
                        cnt_in = '0;
                        state_in = S_FETCH;
                     end
                  end
                  default: begin
                     rsp_in.value = (req_data.reg_index < bmc_pkg::NUM_REGS)
                                    ? regs_ff[req_data.reg_index] : 32'd0;
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         // one byte read issued per cycle, shifted in the cycle after
         S_FETCH: begin
            ram_addr = fpc_ff[ADDR_W-1:0];
            if (rdpend_ff) begin
               ibuf_in = {ibuf_ff[55:0], ram_rdata};
            end
            if (cnt_ff < 4'd8) begin
               fpc_in = fpc_ff + 32'd1;
               cnt_in = cnt_ff + 4'd1;
               rdpend_in = 1'b1;
            end else begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            pc_in = pc_ff + 32'd8;
            icount_in = icount_ff + 32'd1;
            state_in = S_DONE;
            cnt_in = '0;
            case (op)
               bmc_pkg::OP_ADD, bmc_pkg::OP_SUB, bmc_pkg::OP_MUL, bmc_pkg::OP_MOV: begin
                  if (ty <= 8'd1) begin
                     wr = 1'b1;
                     case (op)
                        bmc_pkg::OP_ADD: v = x + y;
                        bmc_pkg::OP_SUB: v = x - y;
                        bmc_pkg::OP_MUL: v = mul_lo;
                        default:         v = y;
                     endcase
                  end
               end
               bmc_pkg::OP_DIV: begin
                  if (ty <= 8'd1) begin
                     div_req.start = 1'b1;
                     state_in = S_DIV;
                  end
               end
               bmc_pkg::OP_LOAD: begin
                  maddr_in = a2; state_in = S_RDW;
               end
               bmc_pkg::OP_STORE: begin
                  maddr_in = a2; wdat_in = x; state_in = S_WRW;
               end
               bmc_pkg::OP_AND: begin v = x & y; wr = 1'b1; end
               bmc_pkg::OP_NOT: begin v = ~x; wr = 1'b1; end
               bmc_pkg::OP_OR:  begin v = x | y; wr = 1'b1; end
               bmc_pkg::OP_XOR: begin v = x ^ y; wr = 1'b1; end
               bmc_pkg::OP_CMP: begin eq_in = (x == y); gt_in = (x > y); end
               bmc_pkg::OP_JMP: pc_in = a2;
               bmc_pkg::OP_JMPE: if (eq_ff && !gt_ff) pc_in = a2;
               bmc_pkg::OP_JMPNE: if (!eq_ff) pc_in = a2;
               bmc_pkg::OP_JMPG: if (gt_ff && !eq_ff) pc_in = a2;
               bmc_pkg::OP_JMPL: if (!gt_ff && !eq_ff) pc_in = a2;
               bmc_pkg::OP_HALT: begin halt_in = 1'b1; st = bmc_pkg::ST_HALT; end
               bmc_pkg::OP_INT: begin
                  if (a2 == 32'd4) begin
                     rw_en = 1'b1; rw_idx = 4'd0; rw_val = icount_ff;
                     v = icount_ff;
                  end
               end
               bmc_pkg::OP_IRET: ;
               bmc_pkg::OP_LOADB: begin maddr_in = a2; state_in = S_READB; end
               bmc_pkg::OP_STOREB: begin
                  maddr_in = a2; wdat_in = {x[7:0], 24'd0}; state_in = S_MEMW;
               end
               bmc_pkg::OP_CALL: begin
                  pc_in = a2;
                  if (sp < bmc_pkg::PUSH_LIMIT) begin
                     st = bmc_pkg::ST_PUSHF;
                  end else begin
                     rw_en = 1'b1; rw_idx = bmc_pkg::SP_INDEX; rw_val = sp - 32'd4;
                     maddr_in = sp - 32'd4; wdat_in = pc_ff + 32'd8; state_in = S_WRW;
                  end
               end
               bmc_pkg::OP_PUSH: begin
                  if (sp < bmc_pkg::PUSH_LIMIT) begin
                     st = bmc_pkg::ST_PUSHF;
                  end else if (ty == 8'd0 || ty == 8'd2) begin
                     rw_en = 1'b1; rw_idx = bmc_pkg::SP_INDEX; rw_val = sp - 32'd4;
                     maddr_in = sp - 32'd4; wdat_in = (ty == 8'd0) ? x : a2;
                     state_in = S_WRW;
                  end else begin
                     st = bmc_pkg::ST_BADTYPE;
                  end
               end
               bmc_pkg::OP_RET, bmc_pkg::OP_POP: begin
                  if (sp > bmc_pkg::POP_LIMIT) begin
                     st = bmc_pkg::ST_POPF;
                  end else begin
                     rw_en = 1'b1; rw_idx = bmc_pkg::SP_INDEX; rw_val = sp + 32'd4;
                     maddr_in = sp; state_in = S_RDW;
                  end
               end
               default: st = bmc_pkg::ST_BADOP;
            endcase
            if (wr && r1 < 8'd12) begin
               rw_en = 1'b1; rw_idx = r1[3:0]; rw_val = v;
            end
            rsp_in.status = st;
            rsp_in.value = (wr && r1 < 8'd12) || (op == bmc_pkg::OP_INT) ? v : 32'd0;
         end
         // big-endian word read, four bytes
         S_RDW: begin
            ram_addr = maddr_ff[ADDR_W-1:0];
            if (rdpend_ff) begin
               rword_in = {rword_ff[23:0], ram_rdata};
            end
            if (cnt_ff < 4'd4) begin
               maddr_in = maddr_ff + 32'd1;
               cnt_in = cnt_ff + 4'd1;
               rdpend_in = 1'b1;
            end else begin
               // last byte arrives this cycle
               state_in = S_DONE;
               if (op == bmc_pkg::OP_RET) begin
                  pc_in = rword_in;
               end else begin
                  if (r1 < 8'd12) begin
                     rw_en = 1'b1; rw_idx = r1[3:0]; rw_val = rword_in;
                     rsp_in.value = rword_in;
                  end
               end
            end
         end
         S_READB: begin
            if (rdpend_ff) begin
               state_in = S_DONE;
               if (r1 < 8'd12) begin
                  rw_en = 1'b1; rw_idx = r1[3:0]; rw_val = {24'd0, ram_rdata};
                  rsp_in.value = {24'd0, ram_rdata};
               end
            end else begin
               rdpend_in = 1'b1;
            end
         end
         S_WRW: begin
            ram_we = 1'b1;
            ram_wdata = wdat_ff[31:24];
            maddr_in = maddr_ff + 32'd1;
            wdat_in = {wdat_ff[23:0], 8'd0};
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'd3) state_in = S_DONE;
         end
         S_MEMW: begin
            ram_we = 1'b1;
            ram_wdata = wdat_ff[31:24];
            state_in = S_DONE;
         end
         S_DIV: begin
            if (div_rsp.done) begin
               state_in = S_DONE;
               v = (y == 32'd0) ? 32'hFFFF_FFFF : div_rsp.quotient;
               if (ty == 8'd0 && a2 < 32'd12) begin
                  rw2_en = 1'b1; rw2_idx = a2[3:0];
                  rw2_val = (y == 32'd0) ? x : div_rsp.remainder;
               end
               if (r1 < 8'd12) begin
                  rw_en = 1'b1; rw_idx = r1[3:0]; rw_val = v;
                  rsp_in.value = v;
               end
            end
         end
         S_DONE: begin
            rsp_in.pc = pc_ff;
            rsp_in.equal_flag = eq_ff;
            rsp_in.greater_flag = gt_ff;
            rspv_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         pc_ff     <= '0;
         icount_ff <= '0;
         eq_ff     <= 1'b0;
         gt_ff     <= 1'b0;
         halt_ff   <= 1'b0;
         rspv_ff   <= 1'b0;
         rdpend_ff <= 1'b0;
         cnt_ff    <= '0;
         for (int i = 0; i < 12; i++) begin
            regs_ff[i] <= (i == 11) ? bmc_pkg::SP_RESET : 32'd0;
         end
      end else begin
         state_ff  <= state_in;
         pc_ff     <= pc_in;
         icount_ff <= icount_in;
         eq_ff     <= eq_in;
         gt_ff     <= gt_in;
         halt_ff   <= halt_in;
         rspv_ff   <= rspv_in;
         rdpend_ff <= rdpend_in;
         cnt_ff    <= cnt_in;
         // remainder first, quotient takes a shared index
         if (rw2_en && !(rw_en && rw_idx == rw2_idx)) regs_ff[rw2_idx] <= rw2_val;
         if (rw_en)  regs_ff[rw_idx]  <= rw_val;
      end
      ibuf_ff  <= ibuf_in;
      maddr_ff <= maddr_in;
      wdat_ff  <= wdat_in;
      rword_ff <= rword_in;
      fpc_ff   <= fpc_in;
      rsp_ff   <= rsp_in;
   end

   `BMC_ASSERT_IMP(a_ready_idle, clock, reset, req_ready, state_ff == S_IDLE && !rspv_ff, "ready outside idle")
   `BMC_ASSERT_NEXT(a_done_rsp, clock, reset, state_ff == S_DONE, rspv_ff, "done without response")
   `BMC_ASSERT_NEXT(a_halt_sticky, clock, reset, halt_ff, halt_ff, "halt cleared")
   `BMC_ASSERT_IMP(a_sp_write, clock, reset, rw_en && rw2_en, state_ff == S_DIV, "dual write outside divide")
endmodule
